// ----- rtl/core/afbv_pkg.sv -----
// Shared types, constants and digit arithmetic for the ASCII frame decoder.
`timescale 1ns / 1ps

package afbv_pkg;

  localparam int NUM_VALUES       = 4;
  localparam int RESTART_POSITION = 49;
  localparam int DIGITS_PER_VALUE = 4;
  localparam int STORE_DEPTH      = DIGITS_PER_VALUE * NUM_VALUES + 2;
  localparam int END_POSITION     = DIGITS_PER_VALUE * NUM_VALUES + 1;
  localparam int STORE_IDX_W      = $clog2(STORE_DEPTH);
  localparam int POS_W            = 6;
  localparam int NUM_OUT          = 4;
  localparam int VALUE_W          = 16;
  localparam int BYTE_W           = 8;
  localparam int TICK_W           = 16;

  localparam logic [TICK_W-1:0]  TIMEOUT_RESET = 16'd1000;

  localparam logic [BYTE_W-1:0]  CHAR_A     = 8'd65;
  localparam logic [BYTE_W-1:0]  CHAR_B     = 8'd66;
  localparam logic [BYTE_W-1:0]  CHAR_SPACE = 8'h20;
  localparam logic [VALUE_W-1:0] CHAR_ZERO  = 16'h0030;

  // Weights of the four digits of one value, most significant first.
  localparam logic [VALUE_W-1:0] DIGIT_WEIGHT [DIGITS_PER_VALUE] =
    '{16'd1000, 16'd100, 16'd10, 16'd1};

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value_0;
    logic [VALUE_W-1:0] value_1;
    logic [VALUE_W-1:0] value_2;
    logic [VALUE_W-1:0] value_3;
  } result_t;

  typedef logic [STORE_DEPTH-1:0][BYTE_W-1:0] store_t;
  typedef logic [NUM_VALUES-1:0][VALUE_W-1:0] values_t;

  // Contribution of one ASCII digit, wrapping modulo 2^16 for non-digits.
  function automatic logic [VALUE_W-1:0] digit_term(input logic [BYTE_W-1:0] b,
                                                    input logic [VALUE_W-1:0] weight);
    logic [VALUE_W-1:0]   d;
    logic [2*VALUE_W-1:0] p;
    d = {{(VALUE_W-BYTE_W){1'b0}}, b} - CHAR_ZERO;
    p = d * weight;
    return p[VALUE_W-1:0];
  endfunction

endpackage

// ----- rtl/core/afbv_decode.sv -----
// Combinational conversion of the stored ASCII digits into binary values.
`timescale 1ns / 1ps

module afbv_decode (
  input  afbv_pkg::store_t  store,
  output afbv_pkg::values_t values
);

  always_comb begin
    logic [afbv_pkg::VALUE_W-1:0] sum;
    logic [afbv_pkg::BYTE_W-1:0]  b;
    values = '0;
    for (int i = 0; i < afbv_pkg::NUM_VALUES; i++) begin
      sum = '0;
      for (int k = 0; k < afbv_pkg::DIGITS_PER_VALUE; k++) begin
        b = store[afbv_pkg::DIGITS_PER_VALUE * i + 1 + k];
        // A space stands for a leading blank and adds nothing.
        if (b != afbv_pkg::CHAR_SPACE) begin
          sum = sum + afbv_pkg::digit_term(b, afbv_pkg::DIGIT_WEIGHT[k]);
        end
      end
      values[i] = sum;
    end
  end

endmodule

// ----- rtl/core/afbv_frame_core.sv -----
// Frame store, write position, tick counter and held values, updated once per request.
`timescale 1ns / 1ps

module afbv_frame_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  afbv_pkg::in_item_t             item,
  input  logic [afbv_pkg::TICK_W-1:0]    timeout_ticks,
  output afbv_pkg::values_t              held
);

  afbv_pkg::store_t                  store;
  logic [afbv_pkg::POS_W-1:0]        pos;
  logic [afbv_pkg::TICK_W-1:0]       tick_count;
  afbv_pkg::values_t                 held_values;

  afbv_pkg::store_t                  store_w;
  logic [afbv_pkg::POS_W-1:0]        pos_w;
  logic                              end_seen;
  afbv_pkg::values_t                 decoded;

  afbv_pkg::store_t                  store_next;
  logic [afbv_pkg::POS_W-1:0]        pos_next;
  logic [afbv_pkg::TICK_W-1:0]       tick_count_next;
  afbv_pkg::values_t                 held_values_next;

  // Byte handling up to and including the restart check.
  always_comb begin
    store_w  = store;
    pos_w    = pos;
    end_seen = 1'b0;
    if (item.rx_byte != '0) begin
      if (pos < afbv_pkg::POS_W'(afbv_pkg::STORE_DEPTH)) begin
        store_w[pos[afbv_pkg::STORE_IDX_W-1:0]] = item.rx_byte;
      end
      pos_w = pos + 1'b1;
    end
    end_seen = (store_w[afbv_pkg::END_POSITION] == afbv_pkg::CHAR_B);
    if (item.rx_byte == afbv_pkg::CHAR_A) begin
      store_w[0] = afbv_pkg::CHAR_A;
      pos_w      = afbv_pkg::POS_W'(1);
    end
    if (pos_w >= afbv_pkg::POS_W'(afbv_pkg::RESTART_POSITION)) begin
      pos_w   = '0;
      store_w = '0;
    end
  end

  afbv_decode u_decode (
    .store  (store_w),
    .values (decoded)
  );

  always_comb begin
    logic [afbv_pkg::TICK_W-1:0] t;
    store_next       = store;
    pos_next         = pos;
    tick_count_next  = tick_count;
    held_values_next = held_values;
    t                = tick_count + 1'b1;
    if (step) begin
      unique case (item.op)
        afbv_pkg::OP_BYTE: begin
          store_next = store_w;
          pos_next   = pos_w;
          if (end_seen) begin
            tick_count_next = '0;
            // A complete frame needs the start mark still in place.
            if (store_w[0] == afbv_pkg::CHAR_A) begin
              held_values_next = decoded;
              store_next       = '0;
            end
          end
        end
        afbv_pkg::OP_TICK: begin
          if (t >= timeout_ticks) begin
            held_values_next = '0;
            tick_count_next  = '0;
          end else begin
            tick_count_next = t;
          end
        end
        afbv_pkg::OP_READ, afbv_pkg::OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store       <= '0;
      pos         <= '0;
      tick_count  <= '0;
      held_values <= '0;
    end else begin
      store       <= store_next;
      pos         <= pos_next;
      tick_count  <= tick_count_next;
      held_values <= held_values_next;
    end
  end

  assign held = held_values;

endmodule

// ----- rtl/core/ascii_frame_to_binary_values_unit.sv -----
// Top level of the ASCII frame decoder: input register, frame core and result register.
`timescale 1ns / 1ps

// A request can be taken in every cycle while in_stall is low. A taken request is held in the
// input register, from which the frame core applies it. A read loads the result register when
// it leaves the input register, so its four values reflect every earlier request. Byte and
// tick requests give no result. in_stall rises only while a read waits in the input register
// behind a result that the output side has not yet taken; the single output register sets
// that limit.
module ascii_frame_to_binary_values_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  afbv_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output afbv_pkg::result_t           out_data,
  input  logic                        cfg_we,
  input  logic [afbv_pkg::TICK_W-1:0] cfg_data
);

  logic                             s1_valid;
  afbv_pkg::in_item_t               s1_item;
  logic [afbv_pkg::TICK_W-1:0]      timeout_ticks;
  logic                             out_free;
  logic                             s1_go;
  afbv_pkg::values_t                held;
  logic [afbv_pkg::NUM_OUT-1:0][afbv_pkg::VALUE_W-1:0] out_vals;

  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_valid && ((s1_item.op != afbv_pkg::OP_READ) || out_free);
  assign in_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= afbv_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks <= cfg_data;
    end
  end

  afbv_frame_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (s1_go),
    .item          (s1_item),
    .timeout_ticks (timeout_ticks),
    .held          (held)
  );

  // Fields beyond the number of held values read as zero.
  for (genvar j = 0; j < afbv_pkg::NUM_OUT; j++) begin : g_out
    if (j < afbv_pkg::NUM_VALUES) begin : g_held
      assign out_vals[j] = held[j];
    end else begin : g_zero
      assign out_vals[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && (s1_item.op == afbv_pkg::OP_READ)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (s1_item.op == afbv_pkg::OP_READ)) begin
      out_data.value_0 <= out_vals[0];
      out_data.value_1 <= out_vals[1];
      out_data.value_2 <= out_vals[2];
      out_data.value_3 <= out_vals[3];
    end
  end

endmodule

// ----- rtl/core/afbv_checker.sv -----
// Port-level checks of the ASCII frame decoder, bound to the top level.
`timescale 1ns / 1ps

module afbv_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input afbv_pkg::in_item_t          in_data,
  input logic                        out_valid,
  input logic                        out_stall,
  input afbv_pkg::result_t           out_data
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A new result only follows a read request that was taken and passed the input register.
  a_rise_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && (in_data.op == afbv_pkg::OP_READ), 2))
    else $error("result appeared without a read request");

  // With the result register empty nothing can hold up the input side.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty result register");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("result pending after reset");

endmodule

bind ascii_frame_to_binary_values_unit afbv_checker u_afbv_checker (.*);
